>>> hdl/ldcm_pkg.sv
// ----------------------------------------------------------------------------
// ldcm_pkg
// Shared constants, codes and controller/datapath interface types for the
// link deframer with CAN mailbox store.
// ----------------------------------------------------------------------------
package ldcm_pkg;

  localparam int MAILBOXES        = 64;
  localparam int MAX_PACKET_BYTES = 1024;

  localparam int BOX_AW = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
  localparam int CNT_W  = $clog2(MAILBOXES + 1);
  localparam int PKT_AW = $clog2(MAX_PACKET_BYTES);
  localparam int FILL_W = $clog2(MAX_PACKET_BYTES + 1);
  // mailbox word: {status[1:0], dlc[3:0], payload[63:0]}
  localparam int BOX_DW = 70;

  localparam logic [7:0] HDR_BYTE = 8'h24;
  localparam logic [7:0] FTR_BYTE = 8'h25;
  localparam logic [7:0] TYPE_CAN = 8'h00;

  // byte offsets inside one 12-byte CAN record
  localparam logic [3:0] REC_BYTES = 4'd12;
  localparam logic [3:0] K_ID_LO   = 4'd1;
  localparam logic [3:0] K_ID_HI   = 4'd2;
  localparam logic [3:0] K_DLC     = 4'd3;
  localparam logic [3:0] K_DATA0   = 4'd4;
  localparam logic [3:0] K_LAST    = 4'd11;
  localparam logic [3:0] DLC_MAX   = 4'd8;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_NEW  = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;

  typedef enum logic [1:0] {
    OP_LINK = 2'd0,
    OP_REG  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    EV_BUSY     = 4'd0,
    EV_APPLIED  = 4'd1,
    EV_MISMATCH = 4'd2,
    EV_SKIP     = 4'd3,
    EV_PARTIAL  = 4'd4,
    EV_ADDED    = 4'd5,
    EV_FULL     = 4'd6,
    EV_DUP      = 4'd7,
    EV_READ     = 4'd8,
    EV_UNKNOWN  = 4'd9
  } ev_t;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_BODY = 2'd1,
    PH_DROP = 2'd2
  } phase_t;

  typedef struct packed {
    logic accept;
    logic link_step;
    logic rec_k_clr;
    logic rec_k_inc;
    logic rec_capture;
    logic rec_next;
    logic scan_start;
    logic scan_inc;
    logic box_add;
    logic box_wr_rec;
    logic box_wr_read;
    logic set_ev;
    ev_t  ev_code;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic rec_more;
    logic rec_k_last;
    logic rec_id_bad;
    logic scan_end;
    logic scan_hit;
    logic box_full;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/ldcm_ram.sv
// ----------------------------------------------------------------------------
// ldcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ldcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ldcm_ctrl.sv
// ----------------------------------------------------------------------------
// ldcm_ctrl
// Sequencer: request intake, record walk, mailbox scan and result hand-off.
// ----------------------------------------------------------------------------
module ldcm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ldcm_pkg::dp_stat_t stat,
  output ldcm_pkg::ctl_cmd_t cmd
);
  import ldcm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DISPATCH = 12'b000000000010,
    S_REC_CHK  = 12'b000000000100,
    S_REC_ADDR = 12'b000000001000,
    S_REC_DATA = 12'b000000010000,
    S_REC_ID   = 12'b000000100000,
    S_SCAN_ADR = 12'b000001000000,
    S_SCAN_CMP = 12'b000010000000,
    S_BOX_RD   = 12'b000100000000,
    S_BOX_WR   = 12'b001000000000,
    S_REC_NEXT = 12'b010000000000,
    S_FINISH   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.ev_code = EV_BUSY;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_LINK: begin
            cmd.link_step = 1'b1;
            state_nxt     = S_REC_CHK;
          end
          OP_REG: begin
            if (stat.box_full) begin
              cmd.set_ev  = 1'b1;
              cmd.ev_code = EV_FULL;
              state_nxt   = S_FINISH;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN_ADR;
            end
          end
          OP_READ: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN_ADR;
          end
          default: begin
            cmd.set_ev  = 1'b1;
            cmd.ev_code = EV_UNKNOWN;
            state_nxt   = S_FINISH;
          end
        endcase
      end
      S_REC_CHK: begin
        if (stat.rec_more) begin
          cmd.rec_k_clr = 1'b1;
          state_nxt     = S_REC_ADDR;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_REC_ADDR: state_nxt = S_REC_DATA;
      S_REC_DATA: begin
        cmd.rec_capture = 1'b1;
        if (stat.rec_k_last) begin
          state_nxt = S_REC_ID;
        end else begin
          cmd.rec_k_inc = 1'b1;
          state_nxt     = S_REC_ADDR;
        end
      end
      S_REC_ID: begin
        if (stat.rec_id_bad) begin
          state_nxt = S_REC_NEXT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN_ADR;
        end
      end
      S_SCAN_ADR: begin
        if (stat.scan_end) begin
          // no mailbox with this id
          unique case (stat.op)
            OP_LINK: state_nxt = S_REC_NEXT;
            OP_REG: begin
              cmd.box_add = 1'b1;
              cmd.set_ev  = 1'b1;
              cmd.ev_code = EV_ADDED;
              state_nxt   = S_FINISH;
            end
            default: begin
              cmd.set_ev  = 1'b1;
              cmd.ev_code = EV_UNKNOWN;
              state_nxt   = S_FINISH;
            end
          endcase
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.scan_hit) begin
          if (stat.op == OP_REG) begin
            cmd.set_ev  = 1'b1;
            cmd.ev_code = EV_DUP;
            state_nxt   = S_FINISH;
          end else begin
            state_nxt = S_BOX_RD;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_SCAN_ADR;
        end
      end
      S_BOX_RD: state_nxt = S_BOX_WR;
      S_BOX_WR: begin
        if (stat.op == OP_LINK) begin
          cmd.box_wr_rec = 1'b1;
          state_nxt      = S_REC_NEXT;
        end else begin
          cmd.box_wr_read = 1'b1;
          cmd.set_ev      = 1'b1;
          cmd.ev_code     = EV_READ;
          state_nxt       = S_FINISH;
        end
      end
      S_REC_NEXT: begin
        cmd.rec_next = 1'b1;
        state_nxt    = S_REC_CHK;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/ldcm_dp.sv
// ----------------------------------------------------------------------------
// ldcm_dp
// Datapath: deframer state, packet buffer, record fields, mailbox memories
// and the result register.
// ----------------------------------------------------------------------------
module ldcm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_link_byte,
  input  logic               in_chunk_end,
  input  logic [15:0]        in_can_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_event_res,
  output logic [3:0]         out_length_out,
  output logic [63:0]        out_payload_out,
  output logic [1:0]         out_mailbox_status,
  input  ldcm_pkg::ctl_cmd_t cmd,
  output ldcm_pkg::dp_stat_t stat
);
  import ldcm_pkg::*;

  // latched request
  op_t         op_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [15:0] can_id_r;

  // deframer
  phase_t            phase_r, phase_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, exp_r, exp_nxt;
  logic [7:0]        hb_r [4];
  logic [7:0]        hb_nxt [4];
  logic [7:0]        b5_r, b6_r, b7_r, b5_nxt, b6_nxt, b7_nxt;
  ev_t               ev_link;
  logic              decided, rec_go, pkt_we;
  logic [15:0]       len;
  logic [FILL_W-1:0] fill_inc;

  // record walk
  logic [FILL_W-1:0] rec_base_r;
  logic [15:0]       rec_left_r;
  logic [3:0]        rec_k_r;
  logic [15:0]       rec_id_r;
  logic [3:0]        rec_dlc_r;
  logic [63:0]       rec_dat_r;
  logic [FILL_W:0]   rec_end;
  logic [FILL_W:0]   pkt_rsum;
  logic [7:0]        pkt_rdata;

  // mailboxes
  logic [CNT_W-1:0]  scan_i_r, box_cnt_r;
  logic [15:0]       id_rdata, scan_key;
  logic [BOX_DW-1:0] box_rdata, box_wdata;
  logic              box_we;
  logic [1:0]        old_st;
  logic [3:0]        old_len;
  logic [63:0]       old_pay, mrg_pay, rd_pay;

  // result
  ev_t         ev_r;
  logic [3:0]  res_len_r;
  logic [63:0] res_pay_r;
  logic [1:0]  res_st_r;
  logic        out_valid_r;
  logic [3:0]  out_ev_r, out_len_r;
  logic [63:0] out_pay_r;
  logic [1:0]  out_st_r;

  // ---------------- link byte step ----------------
  assign fill_inc = fill_r + FILL_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    exp_nxt   = exp_r;
    for (int i = 0; i < 4; i++) begin
      hb_nxt[i] = hb_r[i];
    end
    b5_nxt  = b5_r;
    b6_nxt  = b6_r;
    b7_nxt  = b7_r;
    ev_link = EV_BUSY;
    decided = 1'b0;
    rec_go  = 1'b0;
    pkt_we  = 1'b0;
    len     = '0;
    case (phase_r)
      PH_HEAD: begin
        hb_nxt[fill_r[1:0]] = byte_r;
        if (fill_r[1:0] == 2'd3) begin
          len     = {hb_nxt[2], hb_nxt[1]};
          decided = 1'b1;
          if (len[15]) begin
            hb_nxt[0] = hb_nxt[1];
            hb_nxt[1] = hb_nxt[2];
            hb_nxt[2] = hb_nxt[3];
            fill_nxt  = FILL_W'(3);
            ev_link   = EV_SKIP;
          end else if ({1'b0, len} + 17'd3 > 17'(MAX_PACKET_BYTES)) begin
            fill_nxt  = '0;
            phase_nxt = PH_DROP;
            decided   = 1'b0;
          end else if (len <= 16'd1) begin
            // packet of three or four bytes, all already held
            if (hb_nxt[0] == HDR_BYTE &&
                (len[0] ? hb_nxt[3] : hb_nxt[2]) == FTR_BYTE) begin
              ev_link = EV_APPLIED;
            end else begin
              ev_link = EV_MISMATCH;
            end
            if (len[0]) begin
              fill_nxt = '0;
            end else begin
              hb_nxt[0] = hb_nxt[3];
              fill_nxt  = FILL_W'(1);
            end
          end else begin
            exp_nxt   = FILL_W'(len + 16'd3);
            phase_nxt = PH_BODY;
            fill_nxt  = FILL_W'(4);
          end
        end else begin
          fill_nxt = fill_inc;
        end
      end
      PH_BODY: begin
        pkt_we   = 1'b1;
        fill_nxt = fill_inc;
        if (fill_r == FILL_W'(5)) b5_nxt = byte_r;
        if (fill_r == FILL_W'(6)) b6_nxt = byte_r;
        if (fill_r == FILL_W'(7)) b7_nxt = byte_r;
        if (fill_inc >= exp_r) begin
          decided   = 1'b1;
          fill_nxt  = '0;
          phase_nxt = PH_HEAD;
          if (hb_r[0] == HDR_BYTE && byte_r == FTR_BYTE) begin
            ev_link = EV_APPLIED;
            rec_go  = (exp_r >= FILL_W'(8)) && (b5_nxt == TYPE_CAN) && !b7_nxt[7];
          end else begin
            ev_link = EV_MISMATCH;
          end
        end
      end
      default: ;
    endcase
    if (last_r) begin
      if (!decided && (fill_nxt != '0 || phase_nxt != PH_HEAD)) begin
        ev_link = EV_PARTIAL;
      end
      fill_nxt  = '0;
      phase_nxt = PH_HEAD;
    end
  end

  // ---------------- memories ----------------
  assign pkt_rsum = {1'b0, rec_base_r} + (FILL_W+1)'(rec_k_r);

  ldcm_ram #(.WIDTH(8), .DEPTH(MAX_PACKET_BYTES)) u_pkt_ram (
    .clk   (clk),
    .we    (cmd.link_step & pkt_we),
    .waddr (fill_r[PKT_AW-1:0]),
    .wdata (byte_r),
    .raddr (pkt_rsum[PKT_AW-1:0]),
    .rdata (pkt_rdata)
  );

  ldcm_ram #(.WIDTH(16), .DEPTH(MAILBOXES)) u_id_ram (
    .clk   (clk),
    .we    (cmd.box_add),
    .waddr (scan_i_r[BOX_AW-1:0]),
    .wdata (can_id_r),
    .raddr (scan_i_r[BOX_AW-1:0]),
    .rdata (id_rdata)
  );

  assign old_st  = box_rdata[69:68];
  assign old_len = box_rdata[67:64];
  assign old_pay = box_rdata[63:0];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mrg_pay[8*b +: 8] = (4'(b) < rec_dlc_r) ? rec_dat_r[8*b +: 8] : old_pay[8*b +: 8];
      rd_pay[8*b +: 8]  = (4'(b) < old_len) ? old_pay[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    box_we    = cmd.box_add | cmd.box_wr_rec | cmd.box_wr_read;
    box_wdata = '0;
    if (cmd.box_wr_rec) begin
      box_wdata = {((old_st == ST_NEW) ? ST_OVER : ST_NEW), rec_dlc_r, mrg_pay};
    end else if (cmd.box_wr_read) begin
      box_wdata = {ST_NONE, old_len, old_pay};
    end
  end

  ldcm_ram #(.WIDTH(BOX_DW), .DEPTH(MAILBOXES)) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (scan_i_r[BOX_AW-1:0]),
    .wdata (box_wdata),
    .raddr (scan_i_r[BOX_AW-1:0]),
    .rdata (box_rdata)
  );

  // ---------------- status ----------------
  assign rec_end  = {1'b0, rec_base_r} + (FILL_W+1)'(REC_BYTES);
  assign scan_key = (op_r == OP_LINK) ? rec_id_r : can_id_r;

  always_comb begin
    stat            = '0;
    stat.op         = op_r;
    stat.rec_more   = (rec_left_r != 16'd0) && (rec_end <= {1'b0, exp_r});
    stat.rec_k_last = (rec_k_r == K_LAST);
    stat.rec_id_bad = rec_id_r[15];
    stat.scan_end   = (scan_i_r == box_cnt_r);
    stat.scan_hit   = (id_rdata == scan_key);
    stat.box_full   = (box_cnt_r >= CNT_W'(MAILBOXES));
    stat.out_free   = !out_valid_r || out_ready;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      fill_r      <= '0;
      exp_r       <= '0;
      box_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.link_step) begin
        phase_r <= phase_nxt;
        fill_r  <= fill_nxt;
        exp_r   <= exp_nxt;
      end
      if (cmd.box_add) begin
        box_cnt_r <= box_cnt_r + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= op_t'(in_opcode);
      byte_r    <= in_link_byte;
      last_r    <= in_chunk_end;
      can_id_r  <= in_can_id;
      res_len_r <= '0;
      res_pay_r <= '0;
      res_st_r  <= '0;
    end
    if (cmd.link_step) begin
      for (int i = 0; i < 4; i++) begin
        hb_r[i] <= hb_nxt[i];
      end
      b5_r       <= b5_nxt;
      b6_r       <= b6_nxt;
      b7_r       <= b7_nxt;
      ev_r       <= ev_link;
      rec_base_r <= FILL_W'(8);
      rec_left_r <= rec_go ? {b7_nxt, b6_nxt} : 16'd0;
    end
    if (cmd.set_ev) begin
      ev_r <= cmd.ev_code;
    end
    if (cmd.rec_k_clr) begin
      rec_k_r <= K_ID_LO;
    end else if (cmd.rec_k_inc) begin
      rec_k_r <= rec_k_r + 4'd1;
    end
    if (cmd.rec_capture) begin
      if (rec_k_r == K_ID_LO) rec_id_r[7:0] <= pkt_rdata;
      if (rec_k_r == K_ID_HI) rec_id_r[15:8] <= pkt_rdata;
      if (rec_k_r == K_DLC) begin
        rec_dlc_r <= (pkt_rdata > 8'(DLC_MAX)) ? DLC_MAX : pkt_rdata[3:0];
      end
      for (int b = 0; b < 8; b++) begin
        if (rec_k_r == K_DATA0 + 4'(b)) rec_dat_r[8*b +: 8] <= pkt_rdata;
      end
    end
    if (cmd.rec_next) begin
      rec_base_r <= rec_end[FILL_W-1:0];
      rec_left_r <= rec_left_r - 16'd1;
    end
    if (cmd.scan_start) begin
      scan_i_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_i_r <= scan_i_r + CNT_W'(1);
    end
    if (cmd.box_wr_read) begin
      res_len_r <= old_len;
      res_pay_r <= rd_pay;
      res_st_r  <= old_st;
    end
    if (cmd.load_out) begin
      out_ev_r  <= ev_r;
      out_len_r <= res_len_r;
      out_pay_r <= res_pay_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_ev_r;
  assign out_length_out     = out_len_r;
  assign out_payload_out    = out_pay_r;
  assign out_mailbox_status = out_st_r;

endmodule

>>> hdl/link_deframer_can_mailbox_store_unit.sv
// A link byte with no record: dispatch, record check, finish; opcode 3 or full store: dispatch,
// finish. Register/read: scan-address and compare per id; a read hit adds a mailbox read and
// write. Footer with records, per record: check, address/data pairs reading the packet buffer,
// id, the id scan, mailbox read and write, next. One request at a time; the next is taken
// the cycle after the result register loads. Reset: sequencer, deframer phase, fill, mailbox
// count and result valid clear; packet buffer and mailbox memories are not cleared.
// ----------------------------------------------------------------------------
// link_deframer_can_mailbox_store_unit
// Link deframer that applies CAN records from packets to a mailbox store.
// ----------------------------------------------------------------------------
module link_deframer_can_mailbox_store_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_link_byte,
  input  logic        in_chunk_end,
  input  logic [15:0] in_can_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic [3:0]  out_length_out,
  output logic [63:0] out_payload_out,
  output logic [1:0]  out_mailbox_status
);
  import ldcm_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ldcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ldcm_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_link_byte       (in_link_byte),
    .in_chunk_end       (in_chunk_end),
    .in_can_id          (in_can_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_length_out     (out_length_out),
    .out_payload_out    (out_payload_out),
    .out_mailbox_status (out_mailbox_status),
    .cmd                (cmd),
    .stat               (stat)
  );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link deframer with CAN mailbox store: directed
// and random requests (link packets, mailbox registers, mailbox reads) are
// driven with random gaps and back-pressure; every result is compared with an
// in-bench model of the deframer and mailbox store.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ldcm_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [7:0]  lbyte;
    logic        last;
    logic [15:0] id;
  } req_t;

  typedef struct packed {
    ev_t         ev;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic [1:0]  st;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [7:0]  in_link_byte = '0;
  logic        in_chunk_end = 1'b0;
  logic [15:0] in_can_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_event_res;
  logic [3:0]  out_length_out;
  logic [63:0] out_payload_out;
  logic [1:0]  out_mailbox_status;

  link_deframer_can_mailbox_store_unit u_top (.*);

  always #2 clk = ~clk;

  // model state
  logic [15:0] mb_id   [MAILBOXES];
  logic [3:0]  mb_dlc  [MAILBOXES];
  logic [63:0] mb_data [MAILBOXES];
  logic [1:0]  mb_st   [MAILBOXES];
  int          mb_cnt;
  logic [7:0]  pkt [MAX_PACKET_BYTES];
  int          fill, want_total;
  phase_t      phase;

  req_t pending_q[$];
  rsp_t expect_q[$];
  int   errors, n_sent, n_got, n_applied, n_reads;
  bit   drain_hold;
  int   in_gap, out_gap;
  bit   in_acc = 1'b0;

  function automatic int find_mb(int id);
    for (int i = 0; i < mb_cnt; i++) if (mb_id[i] == id) return i;
    return mb_cnt;
  endfunction

  function automatic void write_record(int base);
    int id, dlc, k;
    id = {pkt[base+2], pkt[base+1]};
    dlc = pkt[base+3];
    if (id[15]) return;
    if (dlc > 8) dlc = 8;
    k = find_mb(id);
    if (k >= mb_cnt) return;
    mb_dlc[k] = dlc;
    for (int b = 0; b < dlc; b++) mb_data[k][8*b +: 8] = pkt[base+4+b];
    mb_st[k] = (mb_st[k] == ST_NEW) ? ST_OVER : ST_NEW;
  endfunction

  function automatic ev_t check_pkt(int total);
    int num;
    if (total < 3 || total > MAX_PACKET_BYTES) return EV_MISMATCH;
    if (pkt[0] != HDR_BYTE || pkt[total-1] != FTR_BYTE) return EV_MISMATCH;
    if (total < 8 || pkt[5] != TYPE_CAN) return EV_APPLIED;
    num = {pkt[7], pkt[6]};
    if (num[15]) return EV_APPLIED;
    for (int j = 0; j < num && 8 + 12*(j+1) <= total; j++) write_record(8 + 12*j);
    return EV_APPLIED;
  endfunction

  function automatic ev_t deframe(logic [7:0] b, logic last);
    ev_t ev;
    bit  decided;
    int  len, total, rest;
    ev = EV_BUSY;
    decided = 0;
    if (phase == PH_HEAD) begin
      if (fill < 4) begin
        pkt[fill] = b;
        fill++;
      end
      if (fill >= 4) begin
        len = {pkt[2], pkt[1]};
        decided = 1;
        if (len[15]) begin
          pkt[0] = pkt[1]; pkt[1] = pkt[2]; pkt[2] = pkt[3];
          fill = 3;
          ev = EV_SKIP;
        end else if (len + 3 > MAX_PACKET_BYTES) begin
          fill = 0;
          phase = PH_DROP;
          decided = 0;
        end else if (len + 3 <= 4) begin
          total = len + 3;
          rest = 4 - total;
          ev = check_pkt(total);
          if (rest) pkt[0] = pkt[total];
          fill = rest;
        end else begin
          want_total = len + 3;
          phase = PH_BODY;
        end
      end
    end else if (phase == PH_BODY) begin
      if (fill < MAX_PACKET_BYTES) begin
        pkt[fill] = b;
        fill++;
      end
      if (fill >= want_total) begin
        ev = check_pkt(want_total);
        decided = 1;
        fill = 0;
        phase = PH_HEAD;
      end
    end
    if (last) begin
      if (!decided && (fill > 0 || phase != PH_HEAD)) ev = EV_PARTIAL;
      fill = 0;
      phase = PH_HEAD;
    end
    return ev;
  endfunction

  function automatic rsp_t predict_result(req_t r);
    rsp_t o;
    int   k;
    o = '{ev: EV_UNKNOWN, dlc: '0, data: '0, st: '0};
    case (r.op)
      OP_LINK: o.ev = deframe(r.lbyte, r.last);
      OP_REG: begin
        if (mb_cnt >= MAILBOXES) o.ev = EV_FULL;
        else if (find_mb(r.id) != mb_cnt) o.ev = EV_DUP;
        else begin
          mb_id[mb_cnt] = r.id; mb_dlc[mb_cnt] = '0;
          mb_data[mb_cnt] = '0; mb_st[mb_cnt] = ST_NONE;
          mb_cnt++;
          o.ev = EV_ADDED;
        end
      end
      OP_READ: begin
        k = find_mb(r.id);
        if (k < mb_cnt) begin
          o.dlc = (mb_dlc[k] > 8) ? 4'd8 : mb_dlc[k];
          o.data = mb_data[k];
          if (o.dlc < 8) o.data &= (64'd1 << (8*o.dlc)) - 64'd1;
          o.st = mb_st[k];
          mb_st[k] = ST_NONE;
          o.ev = EV_READ;
        end
      end
      default: o.ev = EV_UNKNOWN;
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input handshake as seen at the rising edge
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && in_ready;
  end

  // driver: present one request at a time, change on falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        // accepted at the last rising edge
        expect_q.push_back(predict_result(pending_q.pop_front()));
        n_sent++;
        in_gap = pick_gap();
      end
      if (in_acc || !in_valid) begin
        if (in_gap > 0 || drain_hold || pending_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid     <= 1'b1;
          in_opcode    <= pending_q[0].op;
          in_link_byte <= pending_q[0].lbyte;
          in_chunk_end <= pending_q[0].last;
          in_can_id    <= pending_q[0].id;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) out_gap = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      n_got++;
      if (expect_q.size() == 0) begin
        $error("result with no request pending: event %0d", out_event_res);
        errors++;
      end else begin
        e = expect_q.pop_front();
        if (e.ev == EV_APPLIED) n_applied++;
        if (e.ev == EV_READ) n_reads++;
        if (out_event_res != e.ev) begin
          $error("event_res exp %0d got %0d", e.ev, out_event_res); errors++;
        end
        if (out_length_out != e.dlc) begin
          $error("length_out exp %0d got %0d", e.dlc, out_length_out); errors++;
        end
        if (out_payload_out != e.data) begin
          $error("payload_out exp %h got %h", e.data, out_payload_out); errors++;
        end
        if (out_mailbox_status != e.st) begin
          $error("mailbox_status exp %0d got %0d", e.st, out_mailbox_status);
          errors++;
        end
      end
    end
  end

  task automatic push_req(op_t op, logic [7:0] b, logic last, logic [15:0] id);
    pending_q.push_back('{op: op, lbyte: b, last: last, id: id});
  endtask

  task automatic push_byte(logic [7:0] b, logic last = 1'b0);
    push_req(OP_LINK, b, last, 16'($urandom));
  endtask

  // one packet of CAN records; ids drawn from the known list most of the time
  task automatic push_packet(logic [15:0] ids[$], int nrec, bit bad_ftr, bit cut,
                             int count_field);
    logic [7:0] body[$];
    logic [15:0] id;
    int len, dlc;
    body.push_back(8'($urandom)); body.push_back(8'($urandom));
    body.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : TYPE_CAN);
    body.push_back(count_field[7:0]); body.push_back(count_field[15:8]);
    for (int j = 0; j < nrec; j++) begin
      if (ids.size() > 0 && $urandom_range(0, 9) != 0) id = ids[$urandom_range(0, ids.size()-1)];
      else id = 16'($urandom);
      dlc = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
      body.push_back(8'($urandom)); body.push_back(id[7:0]); body.push_back(id[15:8]);
      body.push_back(8'(dlc));
      for (int k = 0; k < 8; k++) body.push_back(8'($urandom));
    end
    if ($urandom_range(0, 5) == 0) body.push_back(8'($urandom));
    len = body.size() + 1;
    push_byte(HDR_BYTE); push_byte(len[7:0]); push_byte(len[15:8]);
    foreach (body[i]) begin
      if (cut && i == body.size() - 1) begin
        push_byte(body[i], 1'b1);
        return;
      end
      push_byte(body[i]);
    end
    push_byte(bad_ftr ? 8'($urandom_range(0, 8'h24)) : FTR_BYTE, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [15:0] ids[$];
    logic [15:0] id;
    int r;
    errors = 0; n_sent = 0; n_got = 0; n_applied = 0; n_reads = 0;
    drain_hold = 0; in_gap = 0; out_gap = 0;
    mb_cnt = 0; fill = 0; want_total = 0; phase = PH_HEAD;

    // directed part
    push_req(OP_READ, 8'h00, 1'b0, 16'h0000);          // unknown mailbox
    push_req(OP_NONE, 8'hFF, 1'b1, 16'hFFFF);          // opcode 3
    push_req(OP_REG, 8'h00, 1'b0, 16'h0000); ids.push_back(16'h0000);
    push_req(OP_REG, 8'h00, 1'b0, 16'h7FFF); ids.push_back(16'h7FFF);
    push_req(OP_REG, 8'h00, 1'b0, 16'hFFFF); ids.push_back(16'hFFFF);
    push_req(OP_REG, 8'h00, 1'b0, 16'h7FFF);           // duplicate
    push_byte(HDR_BYTE); push_byte(8'h00); push_byte(8'h00);   // size 3 packet
    push_byte(HDR_BYTE); push_byte(8'h01); push_byte(8'h00);
    push_byte(FTR_BYTE);                                 // size 4 packet
    push_byte(HDR_BYTE); push_byte(8'h00); push_byte(8'h80);
    push_byte(8'h11, 1'b1);                              // skip, chunk end just clears
    push_byte(HDR_BYTE); push_byte(8'hFF); push_byte(8'h7F);
    push_byte(8'h00); push_byte(8'hFF, 1'b1);            // oversize, dropped
    push_byte(8'hFF, 1'b1);                              // lone byte at chunk end
    push_req(OP_READ, 8'h00, 1'b0, 16'hFFFF);

    // random part: mostly well-formed traffic
    while (pending_q.size() < 1150) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        id = ($urandom_range(0, 3) == 0 && ids.size() > 0) ? ids[$urandom_range(0, ids.size()-1)]
                                                         : 16'($urandom);
        push_req(OP_REG, 8'($urandom), 1'($urandom), id);
        if (ids.size() < 80) ids.push_back(id);
      end else if (r < 25) begin
        id = (ids.size() > 0 && $urandom_range(0, 5) != 0) ? ids[$urandom_range(0, ids.size()-1)]
                                                         : 16'($urandom);
        push_req(OP_READ, 8'($urandom), 1'($urandom), id);
      end else if (r < 27) begin
        push_req(OP_NONE, 8'($urandom), 1'($urandom), 16'($urandom));
      end else if (r < 80) begin
        r = $urandom_range(0, 3);
        push_packet(ids, r, $urandom_range(0, 9) == 0, $urandom_range(0, 12) == 0,
                    ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) : r);
      end else begin
        push_byte(8'($urandom), $urandom_range(0, 4) == 0);
      end
      if (pending_q.size() > 600 && pending_q.size() < 620) begin
        // fill the store to reach the full case
        for (int i = 0; i < 70; i++) push_req(OP_REG, 8'h00, 1'b0, 16'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // hold off the sender midway until the block is drained
    wait (n_sent >= 500);
    drain_hold = 1;
    wait (expect_q.size() == 0 && !in_valid);
    drain_hold = 0;

    wait (pending_q.size() == 0 && expect_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Ran %0d requests, %0d results: %0d packets applied, %0d mailbox reads.",
             n_sent, n_got, n_applied, n_reads);
    if (errors == 0 && expect_q.size() == 0)
      $display("link_deframer_can_mailbox_store_unit test passed");
    else
      $display("link_deframer_can_mailbox_store_unit test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("link_deframer_can_mailbox_store_unit test failed");
    $finish;
  end
endmodule
